@@ hw/rtl/cau_pkg.sv @@
package cau_pkg;

  // Operation codes of an item.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // Remainder width of the divider: a 64-bit magnitude shifted by up to 34
  // fractional bits must fit, as must the divisor shifted by 33.
  localparam int unsigned RemW  = 98;
  localparam int unsigned DenW  = 64;
  localparam int unsigned QuoW  = 33;
  localparam int unsigned TopQ  = 33;

  // Data handed from cell to cell.
  typedef struct packed {
    logic             valid;
    logic             is_div;
    logic             dz;
    logic             ov;
    logic [31:0]      res_re;
    logic [31:0]      res_im;
    logic             neg_re;
    logic             neg_im;
    logic             big_re;
    logic             big_im;
    logic [RemW-1:0]  rem_re;
    logic [RemW-1:0]  rem_im;
    logic [DenW-1:0]  den;
    logic [QuoW-1:0]  q_re;
    logic [QuoW-1:0]  q_im;
  } pipe_t;

endpackage

@@ hw/rtl/cau_front.sv @@
module cau_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [1:0]          operation_i,
  input  logic signed [31:0]  a_re_i,
  input  logic signed [31:0]  a_im_i,
  input  logic signed [31:0]  b_re_i,
  input  logic signed [31:0]  b_im_i,
  output cau_pkg::pipe_t      pipe_o
);
  import cau_pkg::*;

  // Stage 1: products and plain sums.
  logic               v1_q;
  logic [1:0]         op1_q;
  logic               dz1_q;
  logic signed [63:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, s_rr_q, s_ii_q;
  logic signed [32:0] sr_q, si_q;

  // Stage 2: combined terms.
  logic               v2_q, dz2_q;
  logic [1:0]         op2_q;
  logic signed [65:0] x_re_q, x_im_q, x_re_d, x_im_d;
  logic [DenW-1:0]    den2_q;

  // Stage 3: saturated results or divider operands.
  pipe_t p3_q, p3_d;
  pipe_t p4_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q  <= operation_i;
    dz1_q  <= (b_re_i == 32'sd0) && (b_im_i == 32'sd0);
    p_rr_q <= 64'(a_re_i) * 64'(b_re_i);
    p_ii_q <= 64'(a_im_i) * 64'(b_im_i);
    p_ri_q <= 64'(a_re_i) * 64'(b_im_i);
    p_ir_q <= 64'(a_im_i) * 64'(b_re_i);
    s_rr_q <= 64'(b_re_i) * 64'(b_re_i);
    s_ii_q <= 64'(b_im_i) * 64'(b_im_i);
    if (operation_i == OP_ADD) begin
      sr_q <= 33'(a_re_i) + 33'(b_re_i);
      si_q <= 33'(a_im_i) + 33'(b_im_i);
    end else begin
      sr_q <= 33'(a_re_i) - 33'(b_re_i);
      si_q <= 33'(a_im_i) - 33'(b_im_i);
    end
  end

  always_comb begin
    case (op1_q)
      OP_ADD, OP_SUB: begin
        x_re_d = 66'(sr_q);
        x_im_d = 66'(si_q);
      end
      OP_MUL: begin
        x_re_d = (66'(p_rr_q) - 66'(p_ii_q)) >>> FRAC_BITS;
        x_im_d = (66'(p_ri_q) + 66'(p_ir_q)) >>> FRAC_BITS;
      end
      default: begin
        x_re_d = 66'(p_rr_q) + 66'(p_ii_q);
        x_im_d = 66'(p_ir_q) - 66'(p_ri_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    op2_q  <= op1_q;
    dz2_q  <= dz1_q;
    x_re_q <= x_re_d;
    x_im_q <= x_im_d;
    den2_q <= DenW'(s_rr_q) + DenW'(s_ii_q);
  end

  localparam logic signed [65:0] PosMax = 66'sh7FFFFFFF;
  localparam logic signed [65:0] NegMax = -66'sh80000000;

  always_comb begin
    logic [65:0] mag_re, mag_im;
    mag_re = x_re_q[65] ? 66'(-x_re_q) : x_re_q;
    mag_im = x_im_q[65] ? 66'(-x_im_q) : x_im_q;
    p3_d        = '0;
    p3_d.valid  = v2_q;
    p3_d.is_div = (op2_q == OP_DIV);
    p3_d.dz     = dz2_q;
    p3_d.den    = den2_q;
    p3_d.neg_re = x_re_q[65];
    p3_d.neg_im = x_im_q[65];
    p3_d.rem_re = RemW'(mag_re[63:0]) << FRAC_BITS;
    p3_d.rem_im = RemW'(mag_im[63:0]) << FRAC_BITS;
    if (x_re_q > PosMax) begin
      p3_d.res_re = 32'h7FFFFFFF;
      p3_d.ov     = 1'b1;
    end else if (x_re_q < NegMax) begin
      p3_d.res_re = 32'h80000000;
      p3_d.ov     = 1'b1;
    end else begin
      p3_d.res_re = x_re_q[31:0];
    end
    if (x_im_q > PosMax) begin
      p3_d.res_im = 32'h7FFFFFFF;
      p3_d.ov     = 1'b1;
    end else if (x_im_q < NegMax) begin
      p3_d.res_im = 32'h80000000;
      p3_d.ov     = 1'b1;
    end else begin
      p3_d.res_im = x_im_q[31:0];
    end
  end

  // Stage 4: a quotient of 2^33 or more saturates in any case.
  always_comb begin
    logic [RemW-1:0] dsh;
    dsh         = RemW'(p3_q.den) << TopQ;
    p4_d        = p3_q;
    p4_d.big_re = (p3_q.rem_re >= dsh);
    p4_d.big_im = (p3_q.rem_im >= dsh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_q   <= '0;
      pipe_o <= '0;
    end else begin
      p3_q   <= p3_d;
      pipe_o <= p4_d;
    end
  end

endmodule

@@ hw/rtl/cau_div_cell.sv @@
module cau_div_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cau_pkg::pipe_t pipe_i,
  output cau_pkg::pipe_t pipe_o
);
  import cau_pkg::*;

  pipe_t           pipe_d;
  logic [RemW-1:0] dsh;
  logic            ge_re, ge_im;

  // One restoring step: resolves quotient bit SHIFT of both parts.
  always_comb begin
    dsh    = RemW'(pipe_i.den) << SHIFT;
    ge_re  = (pipe_i.rem_re >= dsh);
    ge_im  = (pipe_i.rem_im >= dsh);
    pipe_d = pipe_i;
    pipe_d.q_re = {pipe_i.q_re[QuoW-2:0], ge_re};
    pipe_d.q_im = {pipe_i.q_im[QuoW-2:0], ge_im};
    if (ge_re) begin
      pipe_d.rem_re = pipe_i.rem_re - dsh;
    end
    if (ge_im) begin
      pipe_d.rem_im = pipe_i.rem_im - dsh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_o <= '0;
    end else begin
      pipe_o <= pipe_d;
    end
  end

endmodule

@@ hw/rtl/complex_arithmetic_unit_top.sv @@
// Complex add, subtract, multiply and divide on signed fixed-point operands.
// Start runs to the result strobe through 4 front stages, one
// divider cell per quotient bit 32 down to 0, and one output stage.
// Throughput: one item per cycle; busy is never raised and the receiver
// cannot stall, so every result appears for exactly one cycle.
// Reset (rst_ni low, asynchronous) clears all pipeline valid bits.
module complex_arithmetic_unit_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] a_re_i,
  input  logic signed [31:0] a_im_i,
  input  logic signed [31:0] b_re_i,
  input  logic signed [31:0] b_im_i,
  output logic               result_valid_o,
  output logic signed [31:0] result_re_o,
  output logic signed [31:0] result_im_o,
  output logic               overflow_o,
  output logic               divide_by_zero_o
);
  import cau_pkg::*;

  // The pipeline has no stall path, so an item can be taken every cycle.
  assign busy = 1'b0;

  // chain_q[0] comes from the front end; cell k writes chain_q[k+1].
  pipe_t chain_q [QuoW+1];

  cau_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start),
    .operation_i(operation_i),
    .a_re_i     (a_re_i),
    .a_im_i     (a_im_i),
    .b_re_i     (b_re_i),
    .b_im_i     (b_im_i),
    .pipe_o     (chain_q[0])
  );

  // The divider is a row of identical cells; the first resolves the most
  // significant quotient bit, and every cell passes the remainder onward.
  for (genvar k = 0; k < QuoW; k++) begin : g_cell
    cau_div_cell #(
      .SHIFT(QuoW - 1 - k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .pipe_i(chain_q[k]),
      .pipe_o(chain_q[k+1])
    );
  end

  pipe_t       last;
  logic [31:0] re_d, im_d;
  logic        ov_d, dz_d;

  // A positive quotient above 2^31-1 or a negative one above 2^31 in
  // magnitude saturates; so does any quotient flagged as too big.
  always_comb begin
    last = chain_q[QuoW];
    re_d = last.res_re;
    im_d = last.res_im;
    ov_d = last.ov;
    dz_d = 1'b0;
    if (last.is_div) begin
      ov_d = 1'b0;
      if (last.dz) begin
        re_d = '0;
        im_d = '0;
        dz_d = 1'b1;
      end else begin
        if (!last.neg_re) begin
          if (last.big_re || last.q_re > 33'h07FFFFFFF) begin
            re_d = 32'h7FFFFFFF;
            ov_d = 1'b1;
          end else begin
            re_d = last.q_re[31:0];
          end
        end else begin
          if (last.big_re || last.q_re > 33'h080000000) begin
            re_d = 32'h80000000;
            ov_d = 1'b1;
          end else begin
            re_d = 32'(-last.q_re);
          end
        end
        if (!last.neg_im) begin
          if (last.big_im || last.q_im > 33'h07FFFFFFF) begin
            im_d = 32'h7FFFFFFF;
            ov_d = 1'b1;
          end else begin
            im_d = last.q_im[31:0];
          end
        end else begin
          if (last.big_im || last.q_im > 33'h080000000) begin
            im_d = 32'h80000000;
            ov_d = 1'b1;
          end else begin
            im_d = 32'(-last.q_im);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_re_o      <= re_d;
    result_im_o      <= im_d;
    overflow_o       <= ov_d;
    divide_by_zero_o <= dz_d;
  end

endmodule
